>>> sv/nec_ir_pkg.sv
// Package for the NEC infrared frame decoder: decoder phase type, register
// indexes, event codes, register reset values and the result struct. No dependencies.
`timescale 1ns / 1ps

package nec_ir_pkg;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_MARK  = 2'd1,
        PH_SPACE = 2'd2,
        PH_DATA  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_FRAME  = 2'd1,
        EV_REPEAT = 2'd2
    } event_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int NOM_W       = 16;
    localparam int HALF_W      = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_MARK  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SPACE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_SPACE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_PERIOD   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_PERIOD  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_WINDOW  = 3'd5;

    localparam logic [NOM_W-1:0]  RST_HEADER_MARK  = 16'd9000;
    localparam logic [NOM_W-1:0]  RST_HEADER_SPACE = 16'd4500;
    localparam logic [NOM_W-1:0]  RST_REPEAT_SPACE = 16'd2250;
    localparam logic [NOM_W-1:0]  RST_ONE_PERIOD   = 16'd2250;
    localparam logic [NOM_W-1:0]  RST_ZERO_PERIOD  = 16'd1125;
    localparam logic [HALF_W-1:0] RST_HALF_WINDOW  = 12'd250;

    localparam int FRAME_BITS = 32;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] address;
        logic [7:0] command;
        logic       held_valid;
    } result_t;

endpackage

>>> sv/nec_ir_frame_decoder.sv
// NEC infrared frame decoder top level: per-edge decode state machine,
// configuration registers and a two-entry output buffer. Uses nec_ir_pkg.
`timescale 1ns / 1ps

// Usage
// - s_* channel: one item per receiver pin edge, pin level after the edge
//   (0 = IR active) and a free-running microsecond timestamp.
// - m_* channel: exactly one result item per input item, carrying the
//   event (none, new frame, repeat) and the held address/command/valid flag.
// - cfg_* channel: register writes by index, always ready; write only while
//   no item is in flight. Indexes past the last register are ignored.
// - Results are registered into the output register, or into the skid
//   register while one is stalled. One item per cycle while skid is empty;
//   decode state updates on accept, so the next edge's item follows directly.
// - The output side has an output register and a skid register, so one
//   extra item is taken while a result is stalled; s_tready drops only when
//   both hold results.
// - Reset: registers return to their nominal NEC timings, the decoder goes
//   idle, the held frame clears and both output entries empty.
// - Only the low TIME_BITS bits of the timestamp are used; elapsed time
//   wraps modulo 2^TIME_BITS.
module nec_ir_frame_decoder #(
    parameter int TIME_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [0] pin_level, [32:1] time_us, rest zero

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] address, [15:8] command, [16] held_valid
    output logic [1:0]  m_tuser,   // [1:0] event_kind

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nec_ir_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nec_ir_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CMP_W = TIME_BITS + 1;

    // configuration
    logic [nec_ir_pkg::NOM_W-1:0]  header_mark_reg, header_space_reg, repeat_space_reg;
    logic [nec_ir_pkg::NOM_W-1:0]  one_period_reg, zero_period_reg;
    logic [nec_ir_pkg::HALF_W-1:0] half_window_reg;

    // decode state
    nec_ir_pkg::phase_t   phase_reg, phase_next;
    logic [TIME_BITS-1:0] time_mark_reg, time_mark_next;
    logic [31:0]          shift_bits_reg, shift_bits_next;
    logic [5:0]           bit_count_reg, bit_count_next;
    logic [7:0]           held_address_reg, held_address_next;
    logic [7:0]           held_command_reg, held_command_next;
    logic                 held_valid_reg, held_valid_next;

    // output buffer
    nec_ir_pkg::result_t out_reg, skid_reg, result;
    logic                out_valid_reg, skid_valid_reg;

    logic                 accept;
    logic                 active;
    logic [TIME_BITS-1:0] now, dt;
    logic                 win_mark, win_space, win_repeat, win_one, win_zero;
    logic                 check_ok;
    nec_ir_pkg::event_t   ev;

    function automatic logic in_window(
        input logic [TIME_BITS-1:0]         t,
        input logic [nec_ir_pkg::NOM_W-1:0] nominal,
        input logic [nec_ir_pkg::HALF_W-1:0] half
    );
        logic [nec_ir_pkg::NOM_W:0] lo;
        logic [nec_ir_pkg::NOM_W:0] hi;
        // lower bound saturates at zero
        lo = (nominal > nec_ir_pkg::NOM_W'(half))
           ? ({1'b0, nominal} - (nec_ir_pkg::NOM_W + 1)'(half))
           : '0;
        hi = {1'b0, nominal} + (nec_ir_pkg::NOM_W + 1)'(half);
        return (CMP_W'(t) >= CMP_W'(lo)) && (CMP_W'(t) <= CMP_W'(hi));
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;

    assign active = !s_tdata[0];
    assign now    = s_tdata[TIME_BITS:1];
    assign dt     = now - time_mark_reg;

    assign win_mark   = in_window(dt, header_mark_reg, half_window_reg);
    assign win_space  = in_window(dt, header_space_reg, half_window_reg);
    assign win_repeat = in_window(dt, repeat_space_reg, half_window_reg);
    assign win_one    = in_window(dt, one_period_reg, half_window_reg);
    assign win_zero   = in_window(dt, zero_period_reg, half_window_reg);

    assign check_ok = (shift_bits_reg[15:8] == ~shift_bits_reg[7:0])
                   && (shift_bits_reg[31:24] == ~shift_bits_reg[23:16]);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            nec_ir_pkg::PH_IDLE:
            begin
                if (active)
                    phase_next = nec_ir_pkg::PH_MARK;
            end
            nec_ir_pkg::PH_MARK:
            begin
                phase_next = win_mark ? nec_ir_pkg::PH_SPACE : nec_ir_pkg::PH_IDLE;
            end
            nec_ir_pkg::PH_SPACE:
            begin
                if (!win_repeat && win_space)
                    phase_next = nec_ir_pkg::PH_DATA;
                else
                    phase_next = nec_ir_pkg::PH_IDLE;
            end
            nec_ir_pkg::PH_DATA:
            begin
                if (bit_count_reg[5])
                    phase_next = nec_ir_pkg::PH_IDLE;
                else if (active && !win_one && !win_zero)
                    phase_next = nec_ir_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = nec_ir_pkg::PH_IDLE;
            end
        endcase
    end

    // data path and event
    always_comb
    begin
        time_mark_next    = time_mark_reg;
        shift_bits_next   = shift_bits_reg;
        bit_count_next    = bit_count_reg;
        held_address_next = held_address_reg;
        held_command_next = held_command_reg;
        held_valid_next   = held_valid_reg;
        ev                = nec_ir_pkg::EV_NONE;
        case (phase_reg)
            nec_ir_pkg::PH_IDLE:
            begin
                if (active)
                    time_mark_next = now;
            end
            nec_ir_pkg::PH_MARK:
            begin
                if (win_mark)
                    time_mark_next = now;
                else
                    held_valid_next = 1'b0;
            end
            nec_ir_pkg::PH_SPACE:
            begin
                if (win_repeat)
                begin
                    if (held_valid_reg)
                        ev = nec_ir_pkg::EV_REPEAT;
                end
                else if (win_space)
                begin
                    time_mark_next = now;
                    bit_count_next = '0;
                end
                else
                begin
                    held_valid_next = 1'b0;
                end
            end
            nec_ir_pkg::PH_DATA:
            begin
                if (bit_count_reg[5])
                begin
                    // edge after the last bit ends the frame
                    if (check_ok)
                    begin
                        held_address_next = shift_bits_reg[7:0];
                        held_command_next = shift_bits_reg[23:16];
                        held_valid_next   = 1'b1;
                        ev                = nec_ir_pkg::EV_FRAME;
                    end
                end
                else if (active)
                begin
                    if (win_one || win_zero)
                    begin
                        time_mark_next  = now;
                        bit_count_next  = bit_count_reg + 6'd1;
                        shift_bits_next = {win_one, shift_bits_reg[31:1]};
                    end
                    else
                    begin
                        held_valid_next = 1'b0;
                    end
                end
            end
            default:
            begin
                held_valid_next = held_valid_reg;
            end
        endcase
    end

    always_comb
    begin
        result.event_kind = ev;
        result.address    = held_address_next;
        result.command    = held_command_next;
        result.held_valid = held_valid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_mark_reg  <= nec_ir_pkg::RST_HEADER_MARK;
            header_space_reg <= nec_ir_pkg::RST_HEADER_SPACE;
            repeat_space_reg <= nec_ir_pkg::RST_REPEAT_SPACE;
            one_period_reg   <= nec_ir_pkg::RST_ONE_PERIOD;
            zero_period_reg  <= nec_ir_pkg::RST_ZERO_PERIOD;
            half_window_reg  <= nec_ir_pkg::RST_HALF_WINDOW;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                nec_ir_pkg::REG_HEADER_MARK:  header_mark_reg  <= cfg_data;
                nec_ir_pkg::REG_HEADER_SPACE: header_space_reg <= cfg_data;
                nec_ir_pkg::REG_REPEAT_SPACE: repeat_space_reg <= cfg_data;
                nec_ir_pkg::REG_ONE_PERIOD:   one_period_reg   <= cfg_data;
                nec_ir_pkg::REG_ZERO_PERIOD:  zero_period_reg  <= cfg_data;
                nec_ir_pkg::REG_HALF_WINDOW:  half_window_reg  <= cfg_data[nec_ir_pkg::HALF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= nec_ir_pkg::PH_IDLE;
            time_mark_reg    <= '0;
            shift_bits_reg   <= '0;
            bit_count_reg    <= '0;
            held_address_reg <= '0;
            held_command_reg <= '0;
            held_valid_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            time_mark_reg    <= time_mark_next;
            shift_bits_reg   <= shift_bits_next;
            bit_count_reg    <= bit_count_next;
            held_address_reg <= held_address_next;
            held_command_reg <= held_command_next;
            held_valid_reg   <= held_valid_next;
        end
    end

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= result;
        end
        else if (accept)
        begin
            skid_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_kind;
    assign m_tdata  = {7'b0, out_reg.held_valid, out_reg.command, out_reg.address};

endmodule

>>> sim/nec_ir_frame_decoder_tb.sv
// Testbench for nec_ir_frame_decoder: drives receiver edges shaped as NEC frames, repeats,
// broken frames and noise, and checks every result against an in-bench decode predictor.
// Depends on nec_ir_pkg and nec_ir_frame_decoder.
`timescale 1ns / 1ps

module nec_ir_frame_decoder_tb;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int ITEMS_PER_SETTING = 230;
    localparam int NUM_SETTINGS = 7;

    // Decode predictor plus the queue of results still owed by the block
    class ir_event_scoreboard;
        logic [nec_ir_pkg::NOM_W-1:0]  hdr_mark;
        logic [nec_ir_pkg::NOM_W-1:0]  hdr_space;
        logic [nec_ir_pkg::NOM_W-1:0]  rpt_space;
        logic [nec_ir_pkg::NOM_W-1:0]  one_per;
        logic [nec_ir_pkg::NOM_W-1:0]  zero_per;
        logic [nec_ir_pkg::HALF_W-1:0] half_win;

        nec_ir_pkg::phase_t dec_phase;
        logic [31:0] time_ref;
        logic [31:0] shift_reg;
        int unsigned bit_cnt;
        logic [7:0]  held_addr;
        logic [7:0]  held_cmd;
        logic        held_ok;

        nec_ir_pkg::result_t expected_events[$];
        int errors;

        function new();
            hdr_mark  = nec_ir_pkg::RST_HEADER_MARK;
            hdr_space = nec_ir_pkg::RST_HEADER_SPACE;
            rpt_space = nec_ir_pkg::RST_REPEAT_SPACE;
            one_per   = nec_ir_pkg::RST_ONE_PERIOD;
            zero_per  = nec_ir_pkg::RST_ZERO_PERIOD;
            half_win  = nec_ir_pkg::RST_HALF_WINDOW;
            dec_phase = nec_ir_pkg::PH_IDLE;
            time_ref  = '0;
            shift_reg = '0;
            bit_cnt   = 0;
            held_addr = '0;
            held_cmd  = '0;
            held_ok   = 1'b0;
            errors    = 0;
        endfunction

        function bit in_win(logic [31:0] dt, logic [31:0] nominal);
            logic [31:0] lo;
            logic [31:0] hi;
            lo = (nominal > half_win) ? nominal - half_win : 32'd0;
            hi = nominal + half_win;
            return (dt >= lo) && (dt <= hi);
        endfunction

        function void write_reg(logic [nec_ir_pkg::CFG_INDEX_W-1:0] idx,
                                logic [nec_ir_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                nec_ir_pkg::REG_HEADER_MARK:  hdr_mark  = val;
                nec_ir_pkg::REG_HEADER_SPACE: hdr_space = val;
                nec_ir_pkg::REG_REPEAT_SPACE: rpt_space = val;
                nec_ir_pkg::REG_ONE_PERIOD:   one_per   = val;
                nec_ir_pkg::REG_ZERO_PERIOD:  zero_per  = val;
                nec_ir_pkg::REG_HALF_WINDOW:  half_win  = val[nec_ir_pkg::HALF_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the decoder by one accepted edge and queue the result it owes
        function void note_edge(bit lvl, logic [31:0] ts);
            logic [31:0] dt;
            nec_ir_pkg::event_t ev;
            nec_ir_pkg::result_t r;
            ev = nec_ir_pkg::EV_NONE;
            dt = ts - time_ref;
            case (dec_phase)
                nec_ir_pkg::PH_IDLE:
                    if (!lvl)
                    begin
                        time_ref  = ts;
                        dec_phase = nec_ir_pkg::PH_MARK;
                    end
                nec_ir_pkg::PH_MARK:
                    if (in_win(dt, 32'(hdr_mark)))
                    begin
                        time_ref  = ts;
                        dec_phase = nec_ir_pkg::PH_SPACE;
                    end
                    else
                    begin
                        held_ok   = 1'b0;
                        dec_phase = nec_ir_pkg::PH_IDLE;
                    end
                nec_ir_pkg::PH_SPACE:
                    // repeat window has priority over the frame header window
                    if (in_win(dt, 32'(rpt_space)))
                    begin
                        if (held_ok)
                            ev = nec_ir_pkg::EV_REPEAT;
                        dec_phase = nec_ir_pkg::PH_IDLE;
                    end
                    else if (in_win(dt, 32'(hdr_space)))
                    begin
                        time_ref  = ts;
                        bit_cnt   = 0;
                        dec_phase = nec_ir_pkg::PH_DATA;
                    end
                    else
                    begin
                        held_ok   = 1'b0;
                        dec_phase = nec_ir_pkg::PH_IDLE;
                    end
                default:
                    if (bit_cnt >= nec_ir_pkg::FRAME_BITS)
                    begin
                        // any edge after the last bit closes the frame
                        if (shift_reg[15:8] == ~shift_reg[7:0] &&
                            shift_reg[31:24] == ~shift_reg[23:16])
                        begin
                            held_addr = shift_reg[7:0];
                            held_cmd  = shift_reg[23:16];
                            held_ok   = 1'b1;
                            ev = nec_ir_pkg::EV_FRAME;
                        end
                        dec_phase = nec_ir_pkg::PH_IDLE;
                    end
                    else if (!lvl)
                    begin
                        if (in_win(dt, 32'(one_per)))
                        begin
                            time_ref  = ts;
                            bit_cnt++;
                            shift_reg = {1'b1, shift_reg[31:1]};
                        end
                        else if (in_win(dt, 32'(zero_per)))
                        begin
                            time_ref  = ts;
                            bit_cnt++;
                            shift_reg = {1'b0, shift_reg[31:1]};
                        end
                        else
                        begin
                            held_ok   = 1'b0;
                            dec_phase = nec_ir_pkg::PH_IDLE;
                        end
                    end
            endcase
            r.event_kind = ev;
            r.address    = held_addr;
            r.command    = held_cmd;
            r.held_valid = held_ok;
            expected_events.push_back(r);
        endfunction

        function void check_event(logic [1:0] kind, logic [7:0] addr, logic [7:0] cmd,
                                  logic hv);
            nec_ir_pkg::result_t exp_r;
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d addr %h cmd %h valid %b",
                         $time, kind, addr, cmd, hv);
                errors++;
                return;
            end
            exp_r = expected_events.pop_front();
            if (kind !== exp_r.event_kind)
            begin
                $display("%0t: event_kind expected %0d actual %0d", $time,
                         exp_r.event_kind, kind);
                errors++;
            end
            if (addr !== exp_r.address)
            begin
                $display("%0t: address expected %h actual %h", $time, exp_r.address, addr);
                errors++;
            end
            if (cmd !== exp_r.command)
            begin
                $display("%0t: command expected %h actual %h", $time, exp_r.command, cmd);
                errors++;
            end
            if (hv !== exp_r.held_valid)
            begin
                $display("%0t: held_valid expected %b actual %b", $time,
                         exp_r.held_valid, hv);
                errors++;
            end
        endfunction

        function int pending();
            return expected_events.size();
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [39:0]                        s_tdata = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [23:0]                        m_tdata;
    logic [1:0]                         m_tuser;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [nec_ir_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [nec_ir_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    ir_event_scoreboard sb = new();

    logic [31:0] now_us = '0;
    int  counted = 0;
    bit  src_fast = 1'b0;
    bit  snk_fast = 1'b0;

    nec_ir_frame_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Elapsed time for the next edge, inside or outside the window around nominal
    function automatic logic [31:0] pick_dt(logic [31:0] nominal, bit ok);
        logic [31:0] lo;
        logic [31:0] hi;
        lo = (nominal > sb.half_win) ? nominal - sb.half_win : 32'd0;
        hi = nominal + sb.half_win;
        if (ok)
        begin
            case ($urandom_range(0, 3))
                0: return lo;
                1: return hi;
                default: return lo + $urandom_range(0, hi - lo);
            endcase
        end
        if (lo > 0 && $urandom_range(0, 1) == 1)
            return $urandom_range(0, lo - 1);
        return hi + 1 + $urandom_range(0, 20000);
    endfunction

    // valid stays high between back-to-back items; it is only lowered for a gap
    task automatic send_edge(bit lvl, logic [31:0] ts);
        int gap;
        gap = src_fast ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, ts, lvl};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_edge(lvl, ts);
        counted++;
    endtask

    // bad_at: 0 leader, 1 header space, 2..33 data bit; out of range means clean timing
    task automatic send_frame(bit rpt, logic [31:0] word, int bad_at);
        logic [31:0] dt;
        if ($urandom_range(0, 7) == 0)
            now_us = $urandom;
        else
            now_us += $urandom_range(1000, 60000);
        send_edge(1'b0, now_us);
        now_us += pick_dt(32'(sb.hdr_mark), bad_at != 0);
        send_edge(1'b1, now_us);
        if (bad_at == 0)
            return;
        now_us += pick_dt(rpt ? 32'(sb.rpt_space) : 32'(sb.hdr_space), bad_at != 1);
        send_edge(1'b0, now_us);
        if (rpt || bad_at == 1)
        begin
            send_edge(1'b1, now_us + 32'd560);
            return;
        end
        for (int i = 0; i < nec_ir_pkg::FRAME_BITS; i++)
        begin
            dt = pick_dt(word[i] ? 32'(sb.one_per) : 32'(sb.zero_per), bad_at != i + 2);
            send_edge(1'b1, now_us + dt / 2);
            now_us += dt;
            send_edge(1'b0, now_us);
            if (bad_at == i + 2)
                return;
        end
        now_us += 32'd560;
        send_edge(1'($urandom_range(0, 1)), now_us);
    endtask

    task automatic write_reg(logic [nec_ir_pkg::CFG_INDEX_W-1:0] idx,
                             logic [nec_ir_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic apply_setting(int k);
        logic [15:0] v;
        case (k)
            1:
            begin
                // exact timing only
                write_reg(nec_ir_pkg::REG_HEADER_MARK, 16'd100);
                write_reg(nec_ir_pkg::REG_HEADER_SPACE, 16'd60);
                write_reg(nec_ir_pkg::REG_REPEAT_SPACE, 16'd30);
                write_reg(nec_ir_pkg::REG_ONE_PERIOD, 16'd20);
                write_reg(nec_ir_pkg::REG_ZERO_PERIOD, 16'd10);
                write_reg(nec_ir_pkg::REG_HALF_WINDOW, 16'd0);
            end
            2:
            begin
                write_reg(nec_ir_pkg::REG_HEADER_MARK, 16'hFFFF);
                write_reg(nec_ir_pkg::REG_HEADER_SPACE, 16'hFFFF);
                write_reg(nec_ir_pkg::REG_REPEAT_SPACE, 16'hFFFF);
                write_reg(nec_ir_pkg::REG_ONE_PERIOD, 16'hFFFF);
                write_reg(nec_ir_pkg::REG_ZERO_PERIOD, 16'hFFFF);
                write_reg(nec_ir_pkg::REG_HALF_WINDOW, 16'd4095);
            end
            3:
            begin
                // all windows collapse onto zero and saturate at the low end
                write_reg(nec_ir_pkg::REG_HEADER_MARK, 16'd0);
                write_reg(nec_ir_pkg::REG_HEADER_SPACE, 16'd0);
                write_reg(nec_ir_pkg::REG_REPEAT_SPACE, 16'd0);
                write_reg(nec_ir_pkg::REG_ONE_PERIOD, 16'd0);
                write_reg(nec_ir_pkg::REG_ZERO_PERIOD, 16'd0);
                write_reg(nec_ir_pkg::REG_HALF_WINDOW, 16'($urandom_range(1, 4095)));
            end
            4:
            begin
                // repeat vs header and one vs zero overlap
                write_reg(nec_ir_pkg::REG_HEADER_MARK, 16'($urandom_range(0, 65535)));
                v = 16'($urandom_range(0, 65535));
                write_reg(nec_ir_pkg::REG_HEADER_SPACE, v + 16'($urandom_range(0, 40)));
                write_reg(nec_ir_pkg::REG_REPEAT_SPACE, v);
                v = 16'($urandom_range(0, 65535));
                write_reg(nec_ir_pkg::REG_ONE_PERIOD, v);
                write_reg(nec_ir_pkg::REG_ZERO_PERIOD, v - 16'($urandom_range(0, 40)));
                write_reg(nec_ir_pkg::REG_HALF_WINDOW, 16'($urandom_range(50, 600)));
            end
            5:
            begin
                write_reg(nec_ir_pkg::REG_HEADER_MARK, 16'($urandom_range(0, 65535)));
                write_reg(nec_ir_pkg::REG_HEADER_SPACE, 16'($urandom_range(0, 65535)));
                write_reg(nec_ir_pkg::REG_REPEAT_SPACE, 16'($urandom_range(0, 65535)));
                write_reg(nec_ir_pkg::REG_ONE_PERIOD, 16'($urandom_range(0, 65535)));
                write_reg(nec_ir_pkg::REG_ZERO_PERIOD, 16'($urandom_range(0, 65535)));
                write_reg(nec_ir_pkg::REG_HALF_WINDOW, 16'($urandom_range(0, 4095)));
            end
            default:
            begin
                write_reg(nec_ir_pkg::REG_HEADER_MARK, nec_ir_pkg::RST_HEADER_MARK);
                write_reg(nec_ir_pkg::REG_HEADER_SPACE, nec_ir_pkg::RST_HEADER_SPACE);
                write_reg(nec_ir_pkg::REG_REPEAT_SPACE, nec_ir_pkg::RST_REPEAT_SPACE);
                write_reg(nec_ir_pkg::REG_ONE_PERIOD, nec_ir_pkg::RST_ONE_PERIOD);
                write_reg(nec_ir_pkg::REG_ZERO_PERIOD, nec_ir_pkg::RST_ZERO_PERIOD);
                write_reg(nec_ir_pkg::REG_HALF_WINDOW, 16'(nec_ir_pkg::RST_HALF_WINDOW));
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Result sink with random stalls
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                snk_fast = ~snk_fast;
            stall = snk_fast ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            sb.check_event(m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[16]);
        end
    end

    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int kind;
        logic [7:0] a;
        logic [7:0] c;
        logic [31:0] word;
        @(posedge rst_n);
        @(posedge clk);

        // Directed edges at reset timing
        send_edge(1'b1, 32'h0000_0000);               // inactive edge while idle
        send_edge(1'b0, 32'hFFFF_FFF0);
        send_edge(1'b1, 32'hFFFF_FFF0 + 32'd9000);     // elapsed time across wrap
        send_edge(1'b0, 32'hFFFF_FFF0 + 32'd11250);    // repeat with nothing held
        send_edge(1'b1, 32'hFFFF_FFFF);
        send_edge(1'b0, 32'hFFFF_FFFF);
        send_edge(1'b0, 32'd8748);                     // leader one short of window
        send_edge(1'b0, 32'd10000);
        send_edge(1'b1, 32'd19250);                    // leader at upper bound
        send_edge(1'b0, 32'd24001);                    // space matches neither window
        send_edge(1'b0, 32'd30000);
        send_edge(1'b1, 32'd38750);                    // leader at lower bound
        send_edge(1'b0, 32'd43000);                    // header space at lower bound
        send_edge(1'b1, 32'd43500);                    // ignored in data
        send_edge(1'b0, 32'd44875);                    // bit period out of both windows
        now_us = 32'd100000;

        for (int k = 0; k < NUM_SETTINGS; k++)
        begin
            if (k > 0)
            begin
                s_tvalid <= 1'b0;
                while (sb.pending() != 0) @(posedge clk);
                apply_setting(k);
            end
            counted = 0;
            while (counted < ITEMS_PER_SETTING)
            begin
                src_fast = ($urandom_range(0, 3) == 0);
                kind = $urandom_range(0, 99);
                a = 8'($urandom);
                c = 8'($urandom);
                word = {~c, c, ~a, a};
                if (kind < 50)
                begin
                    send_frame(1'b0, word, -1);
                    repeat ($urandom_range(0, 2)) send_frame(1'b1, word, -1);
                end
                else if (kind < 62)
                    send_frame(1'b1, word, -1);
                else if (kind < 75)
                    send_frame(1'b0, word ^ (32'h1 << $urandom_range(0, 31)), -1);
                else if (kind < 87)
                    send_frame(1'($urandom_range(0, 1)), word, int'($urandom_range(0, 33)));
                else
                begin
                    repeat ($urandom_range(1, 8))
                    begin
                        now_us += $urandom_range(0, 20000);
                        send_edge(1'($urandom_range(0, 1)), now_us);
                    end
                end
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
